>>> design/txc_pkg.sv
// ----------------------------------------------------------------------------
// txc_pkg
// Shared constants and types for the text console writer.
// ----------------------------------------------------------------------------
package txc_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   localparam int CMD_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 7;
   localparam int CELL_W   = 16;
   localparam int ATTR_W   = 8;

   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } command_type;

endpackage

>>> design/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console: cell memory, cursor tracking, scroll and clear sweeps.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low. A put (character or
// newline without scroll) answers in the cycle after it is taken and leaves
// busy low, so puts can issue every cycle. A read holds busy in ST_READ while
// the cell memory's registered read port returns data. A put that scrolls
// copies the screen up one row through the memory's single read and write
// ports, one cell per cycle, and holds busy through ST_SCROLL and ST_DRAIN. A
// clear writes blanks one cell per cycle and holds busy in ST_CLEAR until the
// last cell is written. After reset the same clearing pass runs (busy high, no
// result beat).
// Results appear for exactly one cycle under rsp_valid and cannot be stalled.
// The attribute register may be written at any idle time.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
   parameter int COLUMNS = txc_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = txc_pkg::ROWS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [txc_pkg::CMD_W-1:0]     req_command,
   input  logic [txc_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [txc_pkg::INDEX_W-1:0]   req_cell_index,
   input  logic                          csr_write_enable,
   input  logic [txc_pkg::ATTR_W-1:0]    csr_write_data,
   output logic                          rsp_valid,
   output logic [txc_pkg::ROW_W-1:0]     rsp_cursor_row_out,
   output logic [txc_pkg::COL_W-1:0]     rsp_cursor_col_out,
   output logic [txc_pkg::CELL_W-1:0]    rsp_cell_data,
   output logic                          rsp_scrolled
);
   import txc_pkg::*;

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int RW         = $clog2(ROWS);
   localparam int CW         = $clog2(COLUMNS);
   localparam logic [AW-1:0] LAST_CELL  = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0] LAST_ROW0  = AW'(CELL_COUNT - COLUMNS);
   localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_DRAIN,
      ST_CLEAR
   } state_type;

   state_type         state_ff, state_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [AW-1:0]     base_ff, base_in;     // row_ff * COLUMNS
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic              clear_rsp_ff, clear_rsp_in;
   logic              oob_ff, oob_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   logic              pend_blank_ff, pend_blank_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [CELL_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_scrolled_ff, rsp_scrolled_in;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [CELL_W-1:0] mem_rdata;

   txc_ram #(
      .WIDTH(CELL_W),
      .DEPTH(CELL_COUNT)
   ) u_screen (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   always_comb begin
      state_in        = state_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      base_in         = base_ff;
      cnt_in          = cnt_ff;
      attr_in         = csr_write_enable ? csr_write_data : attr_ff;
      clear_rsp_in    = clear_rsp_ff;
      oob_in          = oob_ff;
      pend_in         = 1'b0;
      pend_addr_in    = pend_addr_ff;
      pend_blank_in   = pend_blank_ff;
      rsp_valid_in    = 1'b0;
      rsp_row_in      = ROW_W'(row_ff);
      rsp_col_in      = COL_W'(col_ff);
      rsp_data_in     = '0;
      rsp_scrolled_in = 1'b0;

      // finish the write half of a scroll copy issued last cycle
      mem_we    = pend_ff;
      mem_waddr = pend_addr_ff;
      mem_wdata = pend_blank_ff ? BLANK_CELL : mem_rdata;
      mem_raddr = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (command_type'(req_command))
                  CMD_PUT: begin
                     if (req_char_code != NEWLINE_CODE) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(base_ff + AW'(col_ff));
                        mem_wdata = {attr_ff, req_char_code};
                     end
                     if (req_char_code == NEWLINE_CODE || col_ff == LAST_COL) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           // scroll: result goes out after the sweep
                           state_in = ST_SCROLL;
                           cnt_in   = '0;
                        end else begin
                           row_in       = RW'(row_ff + 1'b1);
                           base_in      = AW'(base_ff + COLUMNS);
                           rsp_valid_in = 1'b1;
                           rsp_row_in   = ROW_W'(RW'(row_ff + 1'b1));
                           rsp_col_in   = '0;
                        end
                     end else begin
                        col_in       = CW'(col_ff + 1'b1);
                        rsp_valid_in = 1'b1;
                        rsp_col_in   = COL_W'(CW'(col_ff + 1'b1));
                     end
                  end
                  CMD_CLEAR: begin
                     state_in     = ST_CLEAR;
                     cnt_in       = '0;
                     clear_rsp_in = 1'b1;
                     row_in       = '0;
                     col_in       = '0;
                     base_in      = '0;
                  end
                  CMD_READ: begin
                     mem_raddr = AW'(req_cell_index);
                     oob_in    = 32'(req_cell_index) >= 32'(CELL_COUNT);
                     state_in  = ST_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = oob_ff ? '0 : mem_rdata;
            state_in     = ST_IDLE;
         end
         ST_SCROLL: begin
            // read the cell one row below, write it here next cycle
            pend_in       = 1'b1;
            pend_addr_in  = cnt_ff;
            pend_blank_in = cnt_ff >= LAST_ROW0;
            mem_raddr     = (cnt_ff >= LAST_ROW0) ? '0 : AW'(cnt_ff + COLUMNS);
            cnt_in        = AW'(cnt_ff + 1'b1);
            if (cnt_ff == LAST_CELL) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            rsp_valid_in    = 1'b1;
            rsp_scrolled_in = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = BLANK_CELL;
            cnt_in    = AW'(cnt_ff + 1'b1);
            if (cnt_ff == LAST_CELL) begin
               state_in     = ST_IDLE;
               rsp_valid_in = clear_rsp_ff;
               clear_rsp_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         cnt_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         clear_rsp_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         cnt_ff       <= cnt_in;
         attr_ff      <= attr_in;
         clear_rsp_ff <= clear_rsp_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      oob_ff          <= oob_in;
      pend_addr_ff    <= pend_addr_in;
      pend_blank_ff   <= pend_blank_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   assign busy               = state_ff != ST_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_row_out = rsp_row_ff;
   assign rsp_cursor_col_out = rsp_col_ff;
   assign rsp_cell_data      = rsp_data_ff;
   assign rsp_scrolled       = rsp_scrolled_ff;

endmodule

>>> design/txc_ram.sv
// ----------------------------------------------------------------------------
// txc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module txc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/txc_checker.sv
// ----------------------------------------------------------------------------
// txc_checker
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module txc_checker #(
   parameter int COLUMNS = txc_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = txc_pkg::ROWS_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [txc_pkg::CMD_W-1:0]     req_command,
   input logic                          rsp_valid,
   input logic [txc_pkg::ROW_W-1:0]     rsp_cursor_row_out,
   input logic [txc_pkg::COL_W-1:0]     rsp_cursor_col_out,
   input logic [txc_pkg::CELL_W-1:0]    rsp_cell_data,
   input logic                          rsp_scrolled
);
   import txc_pkg::*;

   // an accepted read or clear always sets busy
   a_long_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == CMD_READ || req_command == CMD_CLEAR) |=> busy)
      else $error("read or clear accepted without going busy");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_cursor_col_out) < COLUMNS && 32'(rsp_cursor_row_out) < ROWS)
      else $error("reported cursor outside the screen");

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |->
         rsp_cursor_col_out == '0 && 32'(rsp_cursor_row_out) == ROWS - 1 && rsp_cell_data == '0)
      else $error("scroll beat with wrong cursor or data");

   // a put that leaves the block free answers with a result beat without scroll
   a_put_free: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == CMD_PUT && !busy ##1 !busy |-> rsp_valid && !rsp_scrolled)
      else $error("put finished without a result beat");

endmodule

bind text_console_writer_core txc_checker #(
   .COLUMNS(COLUMNS),
   .ROWS   (ROWS)
) u_txc_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_command       (req_command),
   .rsp_valid         (rsp_valid),
   .rsp_cursor_row_out(rsp_cursor_row_out),
   .rsp_cursor_col_out(rsp_cursor_col_out),
   .rsp_cell_data     (rsp_cell_data),
   .rsp_scrolled      (rsp_scrolled)
);
